@@ sv/bli_pkg.sv @@
// Shared types and constants of the line walker with color interpolation.
// Used by every module of the block; depends on nothing.
package bli_pkg;

    localparam int COORD_BITS = 10;
    localparam int FRAC_BITS  = 16;
    localparam int CHAN_BITS  = 8;
    localparam int ACC_BITS   = CHAN_BITS + FRAC_BITS;
    localparam int FW_BITS    = 11;
    localparam int OFF_BITS   = 22;
    localparam int ERR_BITS   = COORD_BITS + 3;
    localparam int NUM_CHAN   = 3;
    localparam int FQ_DEPTH   = 2;
    localparam int OQ_DEPTH   = 2;

    localparam logic [FW_BITS-1:0] FRAME_WIDTH_RESET = FW_BITS'(512);

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_STEP = 1'b1;

    typedef struct packed {
        logic                  op;
        logic [COORD_BITS-1:0] x_start;
        logic [COORD_BITS-1:0] y_start;
        logic [COORD_BITS-1:0] x_end;
        logic [COORD_BITS-1:0] y_end;
        logic [CHAN_BITS-1:0]  red_start;
        logic [CHAN_BITS-1:0]  green_start;
        logic [CHAN_BITS-1:0]  blue_start;
        logic [CHAN_BITS-1:0]  alpha_start;
        logic [CHAN_BITS-1:0]  red_end;
        logic [CHAN_BITS-1:0]  green_end;
        logic [CHAN_BITS-1:0]  blue_end;
    } t_in_word;

    typedef struct packed {
        logic [COORD_BITS-1:0] pix_x;
        logic [COORD_BITS-1:0] pix_y;
        logic [CHAN_BITS-1:0]  pix_red;
        logic [CHAN_BITS-1:0]  pix_green;
        logic [CHAN_BITS-1:0]  pix_blue;
        logic [CHAN_BITS-1:0]  pix_alpha;
        logic [OFF_BITS-1:0]   pixel_byte_offset;
        logic                  last_pixel;
    } t_out_word;

    // Classified command as it sits in the front queue.
    typedef struct packed {
        logic     is_load;
        t_in_word word;
    } t_cmd;

    // Head of the front queue as seen by the back end.
    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_fq_head;

endpackage

@@ sv/bli_front.sv @@
// Front end: accepts input words, classifies them and holds them in a short queue.
// Depends on bli_pkg.
module bli_front
    import bli_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     push,
    output logic     full,
    input  t_in_word i_in_word,
    output t_fq_head o_head,
    input  logic     i_head_pop
);

    localparam int PTR_BITS = (FQ_DEPTH > 1) ? $clog2(FQ_DEPTH) : 1;
    localparam int CNT_BITS = $clog2(FQ_DEPTH + 1);

    t_cmd                r_mem [FQ_DEPTH];
    logic [PTR_BITS-1:0] r_wp, n_wp;
    logic [PTR_BITS-1:0] r_rp, n_rp;
    logic [CNT_BITS-1:0] r_cnt, n_cnt;
    logic                wr_en;
    logic                rd_en;
    t_cmd                cmd_in;

    assign full   = (r_cnt == CNT_BITS'(FQ_DEPTH));
    assign wr_en  = push && !full;
    assign rd_en  = i_head_pop && (r_cnt != '0);

    always_comb begin
        cmd_in.is_load = (i_in_word.op == OP_LOAD);
        cmd_in.word    = i_in_word;
    end

    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (wr_en) begin
            n_wp = (r_wp == PTR_BITS'(FQ_DEPTH - 1)) ? '0 : r_wp + 1'b1;
        end
        if (rd_en) begin
            n_rp = (r_rp == PTR_BITS'(FQ_DEPTH - 1)) ? '0 : r_rp + 1'b1;
        end
        if (wr_en && !rd_en) begin
            n_cnt = r_cnt + 1'b1;
        end else if (rd_en && !wr_en) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wp] <= cmd_in;
        end
    end

    always_comb begin
        o_head.valid = (r_cnt != '0);
        o_head.cmd   = r_mem[r_rp];
    end

endmodule

@@ sv/bli_div.sv @@
// Restoring divider, one quotient bit per cycle, for the per-pixel color step.
// Depends on bli_pkg.
module bli_div
    import bli_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [ACC_BITS-1:0]   i_num,
    input  logic [COORD_BITS-1:0] i_den,
    output logic                  o_busy,
    output logic                  o_done,
    output logic [ACC_BITS-1:0]   o_quo
);

    localparam int CNT_BITS = $clog2(ACC_BITS + 1);

    logic [CNT_BITS-1:0]   r_cnt;
    logic                  r_done;
    logic [ACC_BITS-1:0]   r_quo;
    logic [COORD_BITS-1:0] r_rem;
    logic [COORD_BITS-1:0] r_den;
    logic [COORD_BITS:0]   trial;
    logic                  ge;
    logic [COORD_BITS-1:0] n_rem;

    assign trial = {r_rem, r_quo[ACC_BITS-1]};
    assign ge    = (trial >= {1'b0, r_den});
    assign n_rem = ge ? COORD_BITS'(trial - {1'b0, r_den}) : trial[COORD_BITS-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else if (i_start) begin
            r_cnt  <= CNT_BITS'(ACC_BITS);
            r_done <= 1'b0;
        end else if (r_cnt != '0) begin
            r_cnt  <= r_cnt - 1'b1;
            r_done <= (r_cnt == CNT_BITS'(1));
        end else begin
            r_done <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_cnt != '0) begin
            r_quo <= {r_quo[ACC_BITS-2:0], ge};
            r_rem <= n_rem;
        end
    end

    assign o_busy = (r_cnt != '0);
    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule

@@ sv/bli_back.sv @@
// Back end: line setup, pixel walk, color accumulation, byte offset and result queue.
// Depends on bli_pkg and bli_div.
module bli_back
    import bli_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [FW_BITS-1:0] i_cfg_wdata,
    input  t_fq_head           i_head,
    output logic               o_head_pop,
    output logic               empty,
    input  logic               pop,
    output t_out_word          o_out_word
);

    localparam int PTR_BITS = (OQ_DEPTH > 1) ? $clog2(OQ_DEPTH) : 1;
    localparam int CNT_BITS = $clog2(OQ_DEPTH + 1);
    localparam int MUL_BITS = COORD_BITS + FW_BITS + 3;

    typedef enum logic [1:0] {
        S_RUN = 2'b01,
        S_DIV = 2'b10
    } t_state;

    t_state r_state;
    logic [FW_BITS-1:0] r_frame_width;

    // Line state.
    logic                       r_line_active;
    logic [COORD_BITS-1:0]      r_x, r_y, r_steps;
    logic signed [ERR_BITS-1:0] r_err, r_inc_str, r_inc_diag;
    logic                       r_major_y, r_xneg, r_yneg;
    logic [CHAN_BITS-1:0]       r_alpha;
    logic [ACC_BITS-1:0]        r_accum [NUM_CHAN];
    logic [ACC_BITS-1:0]        r_cstep [NUM_CHAN];
    logic                       r_cneg  [NUM_CHAN];

    // Result queue.
    t_out_word           r_oq [OQ_DEPTH];
    logic [PTR_BITS-1:0] r_oq_wp, r_oq_rp;
    logic [CNT_BITS-1:0] r_oq_cnt;

    logic front_pop, do_load, do_step, oq_room, oq_rd;
    t_in_word w;

    // Setup values of a load.
    logic                       ld_xneg, ld_yneg, ld_major_y;
    logic [COORD_BITS-1:0]      ld_adx, ld_ady, ld_maj, ld_mnr;
    logic signed [ERR_BITS-1:0] ld_err, ld_inc_str, ld_inc_diag;
    logic [CHAN_BITS-1:0]       ld_cs [NUM_CHAN];
    logic [CHAN_BITS-1:0]       ld_ce [NUM_CHAN];
    logic [CHAN_BITS-1:0]       ld_mag [NUM_CHAN];
    logic                       ld_neg [NUM_CHAN];

    logic                  div_start;
    logic [NUM_CHAN-1:0]   div_busy, div_done;
    logic [ACC_BITS-1:0]   div_quo [NUM_CHAN];
    logic                  all_done;

    t_out_word             res;
    logic                  is_last;
    logic [MUL_BITS-1:0]   lin_addr;

    assign w        = i_head.cmd.word;
    assign oq_room  = (r_oq_cnt < CNT_BITS'(OQ_DEPTH));
    assign front_pop = (r_state == S_RUN) && i_head.valid &&
                       (i_head.cmd.is_load || !r_line_active || oq_room);
    assign do_load  = front_pop && i_head.cmd.is_load;
    assign do_step  = front_pop && !i_head.cmd.is_load && r_line_active;
    assign o_head_pop = front_pop;
    assign empty    = (r_oq_cnt == '0);
    assign oq_rd    = pop && !empty;
    assign all_done = &div_done;

    always_comb begin
        ld_xneg     = (w.x_end < w.x_start);
        ld_yneg     = (w.y_end < w.y_start);
        ld_adx      = ld_xneg ? w.x_start - w.x_end : w.x_end - w.x_start;
        ld_ady      = ld_yneg ? w.y_start - w.y_end : w.y_end - w.y_start;
        ld_major_y  = (ld_ady > ld_adx);
        ld_maj      = ld_major_y ? ld_ady : ld_adx;
        ld_mnr      = ld_major_y ? ld_adx : ld_ady;
        ld_inc_str  = ERR_BITS'({ld_mnr, 1'b0});
        ld_err      = ld_inc_str - ERR_BITS'(ld_maj);
        ld_inc_diag = ld_inc_str - ERR_BITS'({ld_maj, 1'b0});
        ld_cs[0] = w.red_start;
        ld_cs[1] = w.green_start;
        ld_cs[2] = w.blue_start;
        ld_ce[0] = w.red_end;
        ld_ce[1] = w.green_end;
        ld_ce[2] = w.blue_end;
        for (int i = 0; i < NUM_CHAN; i++) begin
            ld_neg[i] = (ld_ce[i] < ld_cs[i]);
            ld_mag[i] = ld_neg[i] ? ld_cs[i] - ld_ce[i] : ld_ce[i] - ld_cs[i];
        end
    end

    assign div_start = do_load && (ld_maj != '0);

    for (genvar g = 0; g < NUM_CHAN; g++) begin : g_div
        bli_div u_div (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_start (div_start),
            .i_num   ({ld_mag[g], {FRAC_BITS{1'b0}}}),
            .i_den   (ld_maj),
            .o_busy  (div_busy[g]),
            .o_done  (div_done[g]),
            .o_quo   (div_quo[g])
        );
    end

    // Pixel result at the current position.
    always_comb begin
        is_last  = (r_steps == '0);
        lin_addr = MUL_BITS'(r_y) * MUL_BITS'(r_frame_width) + MUL_BITS'(r_x);
        res.pix_x             = r_x;
        res.pix_y             = r_y;
        res.pix_red           = r_accum[0][ACC_BITS-1:FRAC_BITS];
        res.pix_green         = r_accum[1][ACC_BITS-1:FRAC_BITS];
        res.pix_blue          = r_accum[2][ACC_BITS-1:FRAC_BITS];
        res.pix_alpha         = r_alpha;
        res.pixel_byte_offset = OFF_BITS'(lin_addr << 2);
        res.last_pixel        = is_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width <= FRAME_WIDTH_RESET;
        end else if (i_cfg_we) begin
            r_frame_width <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_RUN;
            r_line_active <= 1'b0;
        end else begin
            case (r_state)
                S_RUN: begin
                    if (do_load) begin
                        r_line_active <= 1'b1;
                        if (ld_maj != '0) begin
                            r_state <= S_DIV;
                        end
                    end else if (do_step && is_last) begin
                        r_line_active <= 1'b0;
                    end
                end
                S_DIV: begin
                    if (all_done) begin
                        r_state <= S_RUN;
                    end
                end
                default: begin
                    r_state <= S_RUN;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_load) begin
            r_x        <= w.x_start;
            r_y        <= w.y_start;
            r_steps    <= ld_maj;
            r_err      <= ld_err;
            r_inc_str  <= ld_inc_str;
            r_inc_diag <= ld_inc_diag;
            r_major_y  <= ld_major_y;
            r_xneg     <= ld_xneg;
            r_yneg     <= ld_yneg;
            r_alpha    <= w.alpha_start;
            for (int i = 0; i < NUM_CHAN; i++) begin
                r_accum[i] <= {ld_cs[i], {FRAC_BITS{1'b0}}};
                r_cstep[i] <= '0;
                r_cneg[i]  <= ld_neg[i];
            end
        end else if (do_step && !is_last) begin
            for (int i = 0; i < NUM_CHAN; i++) begin
                r_accum[i] <= r_accum[i] + r_cstep[i];
            end
            if (r_err <= 0) begin
                r_err <= r_err + r_inc_str;
                if (r_major_y) begin
                    r_y <= r_yneg ? r_y - 1'b1 : r_y + 1'b1;
                end else begin
                    r_x <= r_xneg ? r_x - 1'b1 : r_x + 1'b1;
                end
            end else begin
                r_err <= r_err + r_inc_diag;
                r_x   <= r_xneg ? r_x - 1'b1 : r_x + 1'b1;
                r_y   <= r_yneg ? r_y - 1'b1 : r_y + 1'b1;
            end
            r_steps <= r_steps - 1'b1;
        end else if ((r_state == S_DIV) && all_done) begin
            for (int i = 0; i < NUM_CHAN; i++) begin
                r_cstep[i] <= r_cneg[i] ? ACC_BITS'(-div_quo[i]) : div_quo[i];
            end
        end
    end

    // Result queue bookkeeping.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_oq_wp  <= '0;
            r_oq_rp  <= '0;
            r_oq_cnt <= '0;
        end else begin
            if (do_step) begin
                r_oq_wp <= (r_oq_wp == PTR_BITS'(OQ_DEPTH - 1)) ? '0 : r_oq_wp + 1'b1;
            end
            if (oq_rd) begin
                r_oq_rp <= (r_oq_rp == PTR_BITS'(OQ_DEPTH - 1)) ? '0 : r_oq_rp + 1'b1;
            end
            if (do_step && !oq_rd) begin
                r_oq_cnt <= r_oq_cnt + 1'b1;
            end else if (oq_rd && !do_step) begin
                r_oq_cnt <= r_oq_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_step) begin
            r_oq[r_oq_wp] <= res;
        end
    end

    assign o_out_word = r_oq[r_oq_rp];

`ifndef SYNTHESIS
    a_no_pop_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> !front_pop)
        else $error("front queue popped while the color step was being divided");

    a_div_running: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (div_busy[0] || div_done[0]))
        else $error("waiting on a divider that is neither busy nor done");

    a_last_ends_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (do_step && is_last) |=> !r_line_active)
        else $error("line still active after its last pixel");

    a_oq_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_oq_cnt == CNT_BITS'(OQ_DEPTH)) |=> (r_oq_cnt <= CNT_BITS'(OQ_DEPTH)))
        else $error("result queue overflow");
`endif

endmodule

@@ sv/bresenham_line_color_interp_unit.sv @@
// Top level of the line walker with linear RGB interpolation.
// Depends on bli_pkg, bli_front and bli_back (which uses bli_div).
//
// A load word (op 0) sets up a line between two endpoints and produces no
// result; every later step word (op 1) produces the next pixel of the line,
// starting at endpoint 0 and ending at endpoint 1 with last_pixel set, after
// which further step words are consumed without a result until the next load.
// Each pixel carries its position, its red, green and blue values interpolated
// in 8.16 fixed point and truncated, the alpha of endpoint 0 and the byte
// offset 4*(y*frame_width + x) modulo 2^22. Step words sustain one pixel per
// clock as long as the result side keeps popping. A load of a line with
// nonzero length holds the back end while it sets the line up, while the
// per-channel restoring dividers form the color step (one quotient bit per
// cycle, 8 integer plus 16 fraction bits) and while it takes the quotients;
// a zero-length line skips the division. During that time the input side
// keeps accepting words into a two-entry queue, and the two-entry result
// queue keeps delivering pixels already produced. frame_width is written
// through i_cfg_we/i_cfg_wdata, takes effect at once and resets to 512;
// write it only while no line work is pending.
module bresenham_line_color_interp_unit
    import bli_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [FW_BITS-1:0] i_cfg_wdata,
    input  logic               push,
    output logic               full,
    input  t_in_word           i_in_word,
    output logic               empty,
    input  logic               pop,
    output t_out_word          o_out_word
);

    // Front queue head and its pop travel between the two halves.
    t_fq_head head;
    logic     head_pop;

    bli_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .push       (push),
        .full       (full),
        .i_in_word  (i_in_word),
        .o_head     (head),
        .i_head_pop (head_pop)
    );

    // The back end owns the line state, the dividers and the result queue.
    bli_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_head      (head),
        .o_head_pop  (head_pop),
        .empty       (empty),
        .pop         (pop),
        .o_out_word  (o_out_word)
    );

endmodule

@@ tb/tb_bresenham_line_color_interp_unit.sv @@
// Self-checking testbench for the line walker with RGB interpolation.
// Depends on bli_pkg and bresenham_line_color_interp_unit; it predicts every pixel itself.
module tb_bresenham_line_color_interp_unit;
    import bli_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // Cycles that pass after the last expected pixel before the row width may change.
    // A load may still sit in the dividers, and the front queue holds two words.
    localparam int SETTLE_CYCLES = 60;
    localparam int PHASE_ITEMS   = 205;
    localparam int COORD_MAX     = (1 << COORD_BITS) - 1;

    // Scoreboard: walks each line the same way the block should, keeps the
    // pixels it has worked out in order, and compares them with what pops out.
    class pixel_scoreboard;
        logic [FW_BITS-1:0] fw;
        int errors;
        int checked;
        int line_ends;
        t_out_word expected_pixels[$];

        bit line_on;
        bit y_major;
        bit x_neg;
        bit y_neg;
        logic [COORD_BITS-1:0] px;
        logic [COORD_BITS-1:0] py;
        int steps_to_go;
        int err;
        int inc_straight;
        int inc_diag;
        logic [ACC_BITS-1:0] acc[NUM_CHAN];
        int slope[NUM_CHAN];
        logic [CHAN_BITS-1:0] alpha;

        function new();
            fw = FRAME_WIDTH_RESET;
            errors = 0;
            checked = 0;
            line_ends = 0;
            line_on = 1'b0;
        endfunction

        // Per-pixel color step in 8.16: magnitude truncated, then signed.
        function int color_slope(int s, int e, int steps);
            if (steps == 0)
                return 0;
            if (e >= s)
                return ((e - s) << FRAC_BITS) / steps;
            return -(((s - e) << FRAC_BITS) / steps);
        endfunction

        // Takes one accepted word: a load sets up a line, a step queues the
        // pixel it should produce, if any.
        function void note_input(t_in_word w);
            logic [CHAN_BITS-1:0] c0[NUM_CHAN];
            logic [CHAN_BITS-1:0] c1[NUM_CHAN];
            int adx;
            int ady;
            int maj;
            int mnr;
            longint off;
            t_out_word pix;

            if (w.op == OP_LOAD) begin
                x_neg = w.x_end < w.x_start;
                y_neg = w.y_end < w.y_start;
                adx = x_neg ? int'(w.x_start) - int'(w.x_end) : int'(w.x_end) - int'(w.x_start);
                ady = y_neg ? int'(w.y_start) - int'(w.y_end) : int'(w.y_end) - int'(w.y_start);
                y_major = ady > adx;
                maj = y_major ? ady : adx;
                mnr = y_major ? adx : ady;
                err = 2 * mnr - maj;
                inc_straight = 2 * mnr;
                inc_diag = 2 * (mnr - maj);
                steps_to_go = maj;
                px = w.x_start;
                py = w.y_start;
                c0 = '{w.red_start, w.green_start, w.blue_start};
                c1 = '{w.red_end, w.green_end, w.blue_end};
                for (int i = 0; i < NUM_CHAN; i++) begin
                    acc[i] = {c0[i], {FRAC_BITS{1'b0}}};
                    slope[i] = color_slope(c0[i], c1[i], maj);
                end
                alpha = w.alpha_start;
                line_on = 1'b1;
                return;
            end

            // A step with no line in progress is swallowed without a pixel.
            if (!line_on)
                return;

            off = (longint'(py) * longint'(fw) + longint'(px)) * 4;
            pix.pix_x = px;
            pix.pix_y = py;
            pix.pix_red = acc[0][ACC_BITS-1:FRAC_BITS];
            pix.pix_green = acc[1][ACC_BITS-1:FRAC_BITS];
            pix.pix_blue = acc[2][ACC_BITS-1:FRAC_BITS];
            pix.pix_alpha = alpha;
            pix.pixel_byte_offset = off[OFF_BITS-1:0];
            pix.last_pixel = (steps_to_go == 0);
            expected_pixels.push_back(pix);

            if (steps_to_go == 0) begin
                line_on = 1'b0;
                return;
            end

            for (int i = 0; i < NUM_CHAN; i++)
                acc[i] = acc[i] + slope[i][ACC_BITS-1:0];

            // Classic decision variable: straight along the major axis, or diagonal.
            if (err <= 0) begin
                err += inc_straight;
                if (y_major)
                    py = y_neg ? py - 1'b1 : py + 1'b1;
                else
                    px = x_neg ? px - 1'b1 : px + 1'b1;
            end else begin
                err += inc_diag;
                px = x_neg ? px - 1'b1 : px + 1'b1;
                py = y_neg ? py - 1'b1 : py + 1'b1;
            end
            steps_to_go--;
        endfunction

        // One line per mismatch, and every one is counted.
        task report(string what, longint got_v, longint want_v);
            $display("[%0t] MISMATCH on pixel %0d, %s: got %0d, want %0d",
                     $time, checked, what, got_v, want_v);
            errors++;
        endtask

        task check_result(t_out_word got);
            t_out_word want;
            if (expected_pixels.size() == 0) begin
                report("pixel popped with nothing pending, pix_x", got.pix_x, -1);
                return;
            end
            want = expected_pixels.pop_front();
            checked++;
            if (want.last_pixel)
                line_ends++;
            if (got.pix_x !== want.pix_x)
                report("pix_x", got.pix_x, want.pix_x);
            if (got.pix_y !== want.pix_y)
                report("pix_y", got.pix_y, want.pix_y);
            if (got.pix_red !== want.pix_red)
                report("pix_red", got.pix_red, want.pix_red);
            if (got.pix_green !== want.pix_green)
                report("pix_green", got.pix_green, want.pix_green);
            if (got.pix_blue !== want.pix_blue)
                report("pix_blue", got.pix_blue, want.pix_blue);
            if (got.pix_alpha !== want.pix_alpha)
                report("pix_alpha", got.pix_alpha, want.pix_alpha);
            if (got.pixel_byte_offset !== want.pixel_byte_offset)
                report("pixel_byte_offset", got.pixel_byte_offset, want.pixel_byte_offset);
            if (got.last_pixel !== want.last_pixel)
                report("last_pixel", got.last_pixel, want.last_pixel);
        endtask
    endclass

    logic               i_clk;
    logic               i_rst_n;
    logic               i_cfg_we;
    logic [FW_BITS-1:0] i_cfg_wdata;
    logic               push;
    logic               full;
    t_in_word           i_in_word;
    logic               empty;
    logic               pop;
    t_out_word          o_out_word;

    pixel_scoreboard sb;
    bit idle_on = 1'b1;
    int items_used = 0;
    int loads_sent = 0;

    bresenham_line_color_interp_unit DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .push       (push),
        .full       (full),
        .i_in_word  (i_in_word),
        .empty      (empty),
        .pop        (pop),
        .o_out_word (o_out_word)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Hard stop in case the block hangs; the slowest correct run needs well
    // under a fifth of this.
    initial begin
        #5_000_000;
        $display("Timeout: the line walker stopped making progress");
        $display("Mismatches found");
        $finish;
    end

    function automatic t_in_word random_word();
        logic [127:0] r;
        r = {$urandom(), $urandom(), $urandom(), $urandom()};
        return r[$bits(t_in_word)-1:0];
    endfunction

    // Step words carry random payload, which the block must ignore.
    function automatic t_in_word step_word();
        t_in_word w;
        w = random_word();
        w.op = OP_STEP;
        return w;
    endfunction

    function automatic t_in_word line_word(int x0, int y0, int x1, int y1,
                                           logic [31:0] rgba0, logic [23:0] rgb1);
        t_in_word w;
        w.op = OP_LOAD;
        w.x_start = COORD_BITS'(x0);
        w.y_start = COORD_BITS'(y0);
        w.x_end = COORD_BITS'(x1);
        w.y_end = COORD_BITS'(y1);
        {w.red_start, w.green_start, w.blue_start, w.alpha_start} = rgba0;
        {w.red_end, w.green_end, w.blue_end} = rgb1;
        return w;
    endfunction

    // A coordinate a few pixels away, kept inside the raster.
    function automatic logic [COORD_BITS-1:0] nearby_coord(logic [COORD_BITS-1:0] c);
        int v;
        v = int'(c) + int'($urandom_range(0, 12)) * (($urandom_range(0, 1) != 0) ? 1 : -1);
        if (v < 0)
            v = 0;
        if (v > COORD_MAX)
            v = COORD_MAX;
        return v[COORD_BITS-1:0];
    endfunction

    // Called just after a falling edge. Holds the word until it is taken at a
    // rising edge, then returns at the next falling edge with push still high,
    // so back-to-back words never drop push between them.
    task automatic push_word(input t_in_word w);
        if (idle_on && $urandom_range(0, 11) == 0) begin
            push <= 1'b0;
            repeat ($urandom_range(1, 18)) @(negedge i_clk);
        end
        push      <= 1'b1;
        i_in_word <= w;
        @(posedge i_clk);
        while (full)
            @(posedge i_clk);
        sb.note_input(w);
        items_used++;
        if (w.op == OP_LOAD)
            loads_sent++;
        @(negedge i_clk);
    endtask

    // One random line: load it, then step through it. Most lines are short
    // and walked to the end; a few are long and get cut off by the next load,
    // some are cut short on purpose, and some get stray steps past the end.
    task automatic draw_line();
        t_in_word w;
        int dx;
        int dy;
        int len;
        int n;
        int extra;
        w = random_word();
        w.op = OP_LOAD;
        if ($urandom_range(0, 15) == 0) begin
            w.x_end = w.x_start;
            w.y_end = w.y_start;
        end else if ($urandom_range(0, 7) != 0) begin
            w.x_end = nearby_coord(w.x_start);
            w.y_end = nearby_coord(w.y_start);
        end
        dx = int'(w.x_end) - int'(w.x_start);
        dy = int'(w.y_end) - int'(w.y_start);
        if (dx < 0)
            dx = -dx;
        if (dy < 0)
            dy = -dy;
        len = (dx > dy) ? dx : dy;
        n = len + 1;
        if (len > 60)
            n = $urandom_range(1, 40);
        else if ($urandom_range(0, 7) == 0)
            n = $urandom_range(1, n);
        extra = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 2) : 0;
        push_word(w);
        repeat (n + extra)
            push_word(step_word());
    endtask

    // Lets every pending pixel come out and the dividers go quiet, so the row
    // width can be changed with no line work in flight.
    task automatic drain_pipeline();
        push <= 1'b0;
        while (sb.expected_pixels.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic set_frame_width(input logic [FW_BITS-1:0] fw);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= fw;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        sb.fw = fw;
    endtask

    // Result side: pops, with random stall bursts while idling is on, and checks every word it takes.
    initial begin
        pop <= 1'b0;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            if (idle_on && $urandom_range(0, 11) == 0) begin
                pop <= 1'b0;
                repeat ($urandom_range(1, 18)) @(negedge i_clk);
            end
            pop <= 1'b1;
            @(posedge i_clk);
            if (!empty)
                sb.check_result(o_out_word);
            @(negedge i_clk);
        end
    end

    initial begin
        // Row widths for the random phases: the extremes of the legal range,
        // the largest and smallest values the port can carry, and one in between.
        logic [FW_BITS-1:0] widths[5];
        int phase_start;

        sb = new();
        i_rst_n     <= 1'b0;
        i_cfg_we    <= 1'b0;
        i_cfg_wdata <= '0;
        push        <= 1'b0;
        i_in_word   <= '0;
        widths = '{11'd1, 11'd1024, 11'd2047, 11'd0, 11'd0};
        widths[4] = FW_BITS'($urandom_range(2, 1023));

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed part, run with the reset row width of 512.
        // A step before any load must give nothing.
        push_word(step_word());
        // Zero-length line in the far corner: one pixel, already the last,
        // in the start color. The step after it finds no line.
        push_word(line_word(1023, 1023, 1023, 1023, 32'hFF00_80FF, 24'h00_FF_00));
        push_word(step_word());
        push_word(step_word());
        // Short shallow line, colors rising from black to white, alpha zero.
        push_word(line_word(0, 0, 3, 1, 32'h0000_0000, 24'hFF_FF_FF));
        repeat (4) push_word(step_word());
        // Full-length diagonal against x, colors falling; dropped after three
        // pixels by the next load.
        push_word(line_word(1023, 0, 0, 1023, 32'hFFFF_FF7F, 24'h00_00_00));
        repeat (3) push_word(step_word());
        // Steep line walking down in both axes, mixed color directions.
        push_word(line_word(5, 9, 3, 2, 32'h10F0_8001, 24'hF0_10_80));
        repeat (8) push_word(step_word());

        // Random phases, one per row width. Idling stops for the last phase
        // so the block also runs back to back.
        foreach (widths[p]) begin
            drain_pipeline();
            set_frame_width(widths[p]);
            if (p == 4)
                idle_on = 1'b0;
            phase_start = items_used;
            while (items_used - phase_start < PHASE_ITEMS) begin
                if ($urandom_range(0, 9) == 0)
                    push_word(random_word());
                else
                    draw_line();
            end
        end

        drain_pipeline();
        $display("Walked %0d line loads and checked %0d pixels (%0d line ends) over six row widths,",
                 loads_sent, sb.checked, sb.line_ends);
        $display("including zero-length, interrupted and wrapping-offset lines and idle steps.");
        if (sb.errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

@@ files.f @@
sv/bli_pkg.sv
sv/bli_front.sv
sv/bli_div.sv
sv/bli_back.sv
sv/bresenham_line_color_interp_unit.sv
tb/tb_bresenham_line_color_interp_unit.sv
